// ===== hdl/upd_pkg.sv =====
// Package for the URL percent decoder: payload structs, the command record
// passed from the front part to the back part, character constants and the
// hex digit decoder. No dependencies.
package upd_pkg;

  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChSpace   = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // One classified input byte: up to three bytes to emit, oldest in slot 0.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] data;
    logic            last;
  } cmd_t;

  // Head of the command queue as seen by the back part.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } nibble_t;

  typedef enum logic [2:0] {
    PendNone  = 3'b001,
    PendPct   = 3'b010,
    PendDigit = 3'b100
  } pend_e;

  function automatic nibble_t hex_nibble(input logic [7:0] b);
    nibble_t r;
    r.valid = 1'b1;
    r.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.value = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r.value = b[3:0] + 4'd9;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hdl/upd_front.sv =====
// Front part of the URL percent decoder: tracks the pending escape and turns
// each accepted byte into a command of zero to three output bytes.
// Depends on upd_pkg.
module upd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  upd_pkg::in_item_t in_item_i,
  output logic              cmd_push_o,
  output upd_pkg::cmd_t     cmd_o
);

  upd_pkg::pend_e   state_q, state_d;
  logic [7:0]       digit_q, digit_d;
  logic [3:0][7:0]  outb;
  logic [1:0]       n;
  logic             do_fresh;
  upd_pkg::nibble_t nb, hi;
  logic [7:0]       b;

  assign b  = in_item_i.in_byte;
  assign nb = upd_pkg::hex_nibble(b);
  assign hi = upd_pkg::hex_nibble(digit_q);

  always_comb begin
    outb     = '0;
    n        = 2'd0;
    state_d  = upd_pkg::PendNone;
    digit_d  = digit_q;
    do_fresh = 1'b0;
    case (state_q)
      upd_pkg::PendPct: begin
        if (nb.valid) begin
          state_d = upd_pkg::PendDigit;
          digit_d = b;
        end else begin
          outb[n]  = upd_pkg::ChPercent;
          n        = n + 2'd1;
          do_fresh = 1'b1;
        end
      end
      upd_pkg::PendDigit: begin
        if (nb.valid) begin
          outb[n] = {(hi.valid ? hi.value : 4'd0), nb.value};
          n       = n + 2'd1;
        end else begin
          outb[n]  = upd_pkg::ChPercent;
          n        = n + 2'd1;
          outb[n]  = digit_q;
          n        = n + 2'd1;
          do_fresh = 1'b1;
        end
      end
      default: begin
        do_fresh = 1'b1;
      end
    endcase

    // The byte that broke an escape, or one with nothing held, is taken afresh.
    if (do_fresh) begin
      if (b == upd_pkg::ChPlus) begin
        outb[n] = upd_pkg::ChSpace;
        n       = n + 2'd1;
      end else if (b == upd_pkg::ChPercent) begin
        state_d = upd_pkg::PendPct;
      end else begin
        outb[n] = b;
        n       = n + 2'd1;
      end
    end

    // At the end of a string an unfinished escape is flushed raw.
    if (in_item_i.in_last) begin
      if (state_d == upd_pkg::PendPct || state_d == upd_pkg::PendDigit) begin
        outb[n] = upd_pkg::ChPercent;
        n       = n + 2'd1;
      end
      if (state_d == upd_pkg::PendDigit) begin
        outb[n] = digit_d;
        n       = n + 2'd1;
      end
      state_d = upd_pkg::PendNone;
    end
  end

  assign cmd_o.cnt  = n;
  assign cmd_o.data = outb[2:0];
  assign cmd_o.last = in_item_i.in_last;
  assign cmd_push_o = accept_i && (n != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= upd_pkg::PendNone;
    end else if (accept_i) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      digit_q <= digit_d;
    end
  end

endmodule

// ===== hdl/upd_queue.sv =====
// Short command queue between the front and back parts of the URL percent
// decoder. Depends on upd_pkg.
module upd_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  upd_pkg::cmd_t    cmd_i,
  input  logic             deq_i,
  output logic             full_o,
  output upd_pkg::q_head_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  upd_pkg::cmd_t   store_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o       = (cnt_q == FullCnt);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = store_q[rd_q];

  assign do_wr = push_i && !full_o;
  assign do_rd = deq_i && head_o.valid;

  always_comb begin
    wr_d  = do_wr ? ((wr_q == LastPtr) ? '0 : wr_q + PtrW'(1)) : wr_q;
    rd_d  = do_rd ? ((rd_q == LastPtr) ? '0 : rd_q + PtrW'(1)) : rd_q;
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      store_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== hdl/upd_back.sv =====
// Back part of the URL percent decoder: walks the bytes of the command at the
// queue head into the output register, one byte per cycle while the output is popped or empty. Depends on upd_pkg.
module upd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  upd_pkg::q_head_t   head_i,
  input  logic               pop_i,
  output logic               deq_o,
  output logic               out_valid_o,
  output upd_pkg::out_item_t out_item_o
);

  logic               valid_q;
  logic [1:0]         idx_q;
  upd_pkg::out_item_t out_q;
  logic               advance, final_byte;

  assign advance    = head_i.valid && (!valid_q || pop_i);
  assign final_byte = (idx_q == head_i.cmd.cnt - 2'd1);
  assign deq_o      = advance && final_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (advance) begin
        valid_q <= 1'b1;
        idx_q   <= final_byte ? 2'd0 : idx_q + 2'd1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.out_byte <= head_i.cmd.data[idx_q];
      out_q.out_last <= head_i.cmd.last && final_byte;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== hdl/url_percent_decoder.sv =====
// URL form decoder: '+' becomes a space and '%' with two hex digits becomes
// one byte; broken or unfinished escapes pass through raw. A byte is taken
// every cycle while full is low. The output serialiser sends the results of
// a byte one at a time, so a byte that yields two or three results (a broken
// escape or a flush at the end of a string) holds it longer; the command
// queue of QueueDepth entries absorbs those bursts, and full rises only when
// they come faster than the output drains. When the output side is free, a
// result passes through the command queue and then the output register
// before it is shown. Depends on upd_pkg, upd_front, upd_queue and upd_back.
module url_percent_decoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  upd_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output upd_pkg::out_item_t out_item_o
);

  logic             accept, cmd_push, deq, out_valid;
  upd_pkg::cmd_t    cmd;
  upd_pkg::q_head_t head;

  assign accept = push && !full;

  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_item_i  (in_item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd)
  );

  upd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (cmd),
    .deq_i  (deq),
    .full_o (full),
    .head_o (head)
  );

  upd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_i       (pop),
    .deq_o       (deq),
    .out_valid_o (out_valid),
    .out_item_o  (out_item_o)
  );

  assign empty = !out_valid;

endmodule

// ===== hdl/upd_checker.sv =====
// Port checker for the URL percent decoder and its bind to the top level.
// Depends on upd_pkg and url_percent_decoder.
module upd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input upd_pkg::in_item_t  in_item_i,
  input logic               empty,
  input logic               pop,
  input upd_pkg::out_item_t out_item_o
);

  // A waiting result stays until it is taken.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result withdrawn before it was popped");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(out_item_o))
    else $error("result changed while waiting");

  // The queue only fills up behind a result that is already on show.
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full && empty))
    else $error("input stalled with no result waiting");

  a_full_needs_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without an input request");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .in_item_i  (in_item_i),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);
